/* rtl/core/ats_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants of the alias-table sampler: field widths,
// fixed-point constants, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ats_pkg;

	// Field widths
	localparam int WEIGHT_W = 16;
	localparam int IDX_W    = 8;
	localparam int PROB_W   = 25;
	localparam int FRAC_W   = 24;

	// Fixed point: FRAC_W fraction bits, quotients reach one
	localparam int QW = FRAC_W + 1;
	localparam logic [QW-1:0]     ONE_FX   = QW'(1) << FRAC_W;
	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	// Commands
	typedef enum logic [0:0] {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// Result status
	typedef enum logic [0:0] {
		STATUS_OK  = 1'b0,
		STATUS_ERR = 1'b1
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_RD,
		ST_B_DIVGO,
		ST_B_DIVW,
		ST_B_PUSH,
		ST_P_RD,
		ST_P_WR,
		ST_L_OV,
		ST_L_UN,
		ST_S_OFF,
		ST_S_THR,
		ST_S_DIVW,
		ST_S_WAIT,
		ST_S_RESP
	} st_t;

endpackage
`default_nettype wire

/* rtl/core/ats_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ats_in_if
// Command channel: weight loads and sample draws, valid/ready.
// ----------------------------------------------------------------------------
interface ats_in_if
	import ats_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                command;
	logic [WEIGHT_W-1:0] weight;
	logic                last_weight;
	logic [FRAC_W-1:0]   sample_fraction;

	modport source (output valid, command, weight, last_weight, sample_fraction,
		input ready);
	modport sink (input valid, command, weight, last_weight, sample_fraction,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/ats_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ats_out_if
// Result channel: chosen bin, its probability, remapped fraction, status.
// ----------------------------------------------------------------------------
interface ats_out_if
	import ats_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  bin_index;
	logic [PROB_W-1:0] probability;
	logic [FRAC_W-1:0] remapped_fraction;
	logic              status;

	modport source (output valid, bin_index, probability, remapped_fraction, status,
		input ready);
	modport sink (input valid, bin_index, probability, remapped_fraction, status,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/alias_table_sampler_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alias_table_sampler_core
// Alias-method sampler: loads weights, builds an alias table in RAM, and
// maps a uniform fraction to a bin, its probability and a remapped fraction.
// ----------------------------------------------------------------------------
// Load: the last load, when the weight sum is nonzero, starts a build: per bin a
//   read, divider start, divide and push, then pairing of the under and over stacks.
// Sample: offset, threshold read, remap divide when needed, and result to the
//   output register; straight to the result when no table is valid.
// One transaction at a time; the result register frees the input side.
// Reset clears control state and marks the list closed; RAM is not cleared.
module alias_table_sampler_core
	import ats_pkg::*;
#(
	parameter int MAX_BINS = 256
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ats_in_if.sink    req,
	ats_out_if.source rsp
);
	localparam int AW  = $clog2(MAX_BINS);
	localparam int CW  = AW + 1;
	localparam int SW  = WEIGHT_W + AW;
	localparam int DW  = (SW > QW) ? SW : QW;
	localparam int PW  = QW + CW;
	localparam int SCW = FRAC_W + CW;
	localparam int TW  = QW + AW;
	localparam int SEW = PW + AW;

	st_t state_q, state_d;

	logic [CW-1:0]  cnt_q, idx_q, nu_q, no_q;
	logic [SW-1:0]  sum_q;
	logic           ready_q, closed_q;
	logic [QW-1:0]  p_q;
	logic [PW-1:0]  ph_q;
	logic [SCW-1:0] scaled_s1;
	logic [AW-1:0]  off_q, pick_q;
	logic [FRAC_W-1:0] up_q, remap_q;
	logic           err_q;

	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [PROB_W-1:0] out_prob_q;
	logic [FRAC_W-1:0] out_remap_q;
	logic              out_status_q;

	// memory ports
	logic                w_we;  logic [AW-1:0] w_waddr, w_raddr;
	logic [WEIGHT_W-1:0] w_rdata;
	logic                p_we;  logic [QW-1:0] p_rdata;
	logic                t_we;  logic [AW-1:0] t_waddr, t_raddr;
	logic [TW-1:0]       t_wdata, t_rdata;
	logic                u_we;  logic [AW-1:0] u_waddr, u_raddr;
	logic [SEW-1:0]      u_wdata, u_rdata;
	logic                o_we;  logic [AW-1:0] o_waddr, o_raddr;
	logic [SEW-1:0]      o_wdata, o_rdata;

	// divider
	logic          div_start, div_done;
	logic [DW-1:0] div_num, div_den;
	logic [QW-1:0] div_quot;

	// datapath terms
	logic          in_acc, out_free;
	logic [CW-1:0] base_cnt, new_cnt, nm1, hi, off_full;
	logic [SW-1:0] base_sum, new_sum;
	logic          has_room, do_build;
	logic [SCW-1:0] up_full;
	logic [FRAC_W-1:0] up_c;
	logic [QW-1:0] thr;
	logic [AW-1:0] ali;
	logic          up_lt_q, q_lt_one;
	logic [PW-1:0] u_ph, o_ph, exc;
	logic [AW-1:0] u_bin, o_bin;
	logic [PW:0]   exc_full;
	logic          exc_lt_one, ph_lt_one;
	logic          nu_nz, no_nz;

	function automatic logic [AW-1:0] nm1_of(input logic [CW-1:0] c);
		logic [CW-1:0] d;
		d = c - 1'b1;
		return d[AW-1:0];
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// load bookkeeping
	assign base_cnt = closed_q ? '0 : cnt_q;
	assign base_sum = closed_q ? '0 : sum_q;
	assign has_room = base_cnt < CW'(MAX_BINS);
	assign new_cnt  = base_cnt + (has_room ? CW'(1) : CW'(0));
	assign new_sum  = base_sum + (has_room ? SW'(req.weight) : SW'(0));
	assign do_build = (new_cnt != '0) && (new_sum != '0);

	// sample offset and in-bin fraction
	assign nm1      = cnt_q - 1'b1;
	assign hi       = scaled_s1[SCW-1:FRAC_W];
	assign off_full = (hi > nm1) ? nm1 : hi;
	assign up_full  = scaled_s1 - {off_full, {FRAC_W{1'b0}}};
	assign up_c     = (up_full > SCW'(FRAC_MAX)) ? FRAC_MAX : up_full[FRAC_W-1:0];

	// table entry fields
	assign thr      = t_rdata[TW-1:AW];
	assign ali      = t_rdata[AW-1:0];
	assign up_lt_q  = {1'b0, up_q} < thr;
	assign q_lt_one = thr < ONE_FX;

	// stack pairing
	assign u_ph       = u_rdata[SEW-1:AW];
	assign u_bin      = u_rdata[AW-1:0];
	assign o_ph       = o_rdata[SEW-1:AW];
	assign o_bin      = o_rdata[AW-1:0];
	assign exc_full   = {1'b0, u_ph} + {1'b0, o_ph} - (PW+1)'(ONE_FX);
	assign exc        = exc_full[PW-1:0];
	assign exc_lt_one = exc < PW'(ONE_FX);
	assign ph_lt_one  = ph_q < PW'(ONE_FX);
	assign nu_nz      = nu_q != '0;
	assign no_nz      = no_q != '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req.command == CMD_SAMPLE) begin
						state_d = ready_q ? ST_S_OFF : ST_S_RESP;
					end else if (req.last_weight && do_build) begin
						state_d = ST_B_RD;
					end
				end
			end
			ST_B_RD:    state_d = ST_B_DIVGO;
			ST_B_DIVGO: state_d = ST_B_DIVW;
			ST_B_DIVW:  if (div_done) state_d = ST_B_PUSH;
			ST_B_PUSH: begin
				state_d = (idx_q + 1'b1 == cnt_q) ? ST_P_RD : ST_B_RD;
			end
			ST_P_RD: begin
				if (nu_nz && no_nz) state_d = ST_P_WR;
				else if (no_nz)     state_d = ST_L_OV;
				else if (nu_nz)     state_d = ST_L_UN;
				else                state_d = ST_IDLE;
			end
			ST_P_WR, ST_L_OV, ST_L_UN: state_d = ST_P_RD;
			ST_S_OFF: state_d = ST_S_THR;
			ST_S_THR: begin
				state_d = (up_lt_q || q_lt_one) ? ST_S_DIVW : ST_S_WAIT;
			end
			ST_S_DIVW: if (div_done) state_d = ST_S_RESP;
			ST_S_WAIT: state_d = ST_S_RESP;
			ST_S_RESP: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		w_we    = 1'b0;
		w_waddr = base_cnt[AW-1:0];
		w_raddr = idx_q[AW-1:0];
		p_we    = 1'b0;
		t_we    = 1'b0;
		t_waddr = u_bin;
		t_wdata = {thr, ali};
		t_raddr = off_full[AW-1:0];
		u_we    = 1'b0;
		u_waddr = nu_q[AW-1:0];
		u_wdata = {ph_q, idx_q[AW-1:0]};
		u_raddr = nm1_of(nu_q);
		o_we    = 1'b0;
		o_waddr = no_q[AW-1:0];
		o_wdata = {ph_q, idx_q[AW-1:0]};
		o_raddr = nm1_of(no_q);
		div_start = 1'b0;
		div_num   = DW'(w_rdata);
		div_den   = DW'(sum_q);
		case (state_q)
			ST_IDLE: begin
				w_we = in_acc && (req.command == CMD_LOAD) && has_room;
			end
			ST_B_DIVGO: begin
				div_start = 1'b1;
			end
			ST_B_PUSH: begin
				p_we = 1'b1;
				u_we = ph_lt_one;
				o_we = !ph_lt_one;
			end
			ST_P_WR: begin
				// under bin gets its threshold and the over bin as alias
				t_we    = 1'b1;
				t_waddr = u_bin;
				t_wdata = {u_ph[QW-1:0], o_bin};
				u_waddr = nm1_of(nu_q);
				u_wdata = {exc, o_bin};
				o_waddr = nm1_of(no_q);
				o_wdata = {exc, o_bin};
				u_we    = exc_lt_one;
				o_we    = !exc_lt_one;
			end
			ST_L_OV: begin
				t_we    = 1'b1;
				t_waddr = o_bin;
				t_wdata = {ONE_FX, o_bin};
			end
			ST_L_UN: begin
				t_we    = 1'b1;
				t_waddr = u_bin;
				t_wdata = {ONE_FX, u_bin};
			end
			ST_S_THR: begin
				div_start = up_lt_q || q_lt_one;
				if (up_lt_q) begin
					div_num = DW'(up_q);
					div_den = DW'(thr);
				end else begin
					div_num = DW'(up_q) - DW'(thr);
					div_den = DW'(ONE_FX) - DW'(thr);
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			sum_q    <= '0;
			ready_q  <= 1'b0;
			closed_q <= 1'b1;
			idx_q    <= '0;
			nu_q     <= '0;
			no_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (req.command == CMD_LOAD)) begin
						cnt_q    <= new_cnt;
						sum_q    <= new_sum;
						ready_q  <= 1'b0;
						closed_q <= req.last_weight;
						idx_q    <= '0;
						nu_q     <= '0;
						no_q     <= '0;
					end
				end
				ST_B_PUSH: begin
					idx_q <= idx_q + 1'b1;
					if (ph_lt_one) nu_q <= nu_q + 1'b1;
					else           no_q <= no_q + 1'b1;
				end
				ST_P_RD: begin
					if (!nu_nz && !no_nz) ready_q <= 1'b1;
				end
				ST_P_WR: begin
					// net effect of two pops and one push
					if (exc_lt_one) no_q <= no_q - 1'b1;
					else            nu_q <= nu_q - 1'b1;
				end
				ST_L_OV: no_q <= no_q - 1'b1;
				ST_L_UN: nu_q <= nu_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q     <= !ready_q;
				scaled_s1 <= SCW'(req.sample_fraction) * SCW'(cnt_q);
			end
			ST_B_DIVW: begin
				if (div_done) begin
					p_q  <= div_quot;
					ph_q <= PW'(div_quot) * PW'(cnt_q);
				end
			end
			ST_S_OFF: begin
				off_q <= off_full[AW-1:0];
				up_q  <= up_c;
			end
			ST_S_THR: begin
				pick_q  <= up_lt_q ? off_q : ali;
				remap_q <= '0;
			end
			ST_S_DIVW: begin
				if (div_done) remap_q <= div_quot[FRAC_W] ? FRAC_MAX : div_quot[FRAC_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_S_RESP && out_free) begin
			out_status_q <= err_q ? STATUS_ERR : STATUS_OK;
			out_idx_q    <= err_q ? '0 : IDX_W'(pick_q);
			out_prob_q   <= err_q ? '0 : PROB_W'(p_rdata);
			out_remap_q  <= err_q ? '0 : remap_q;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.bin_index         = out_idx_q;
	assign rsp.probability       = out_prob_q;
	assign rsp.remapped_fraction = out_remap_q;
	assign rsp.status            = out_status_q;

	// memories
	ats_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BINS)) u_wmem (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(req.weight),
		.raddr(w_raddr), .rdata(w_rdata)
	);
	ats_ram #(.WIDTH(QW), .DEPTH(MAX_BINS)) u_pmem (
		.clk(clk), .we(p_we), .waddr(idx_q[AW-1:0]), .wdata(p_q),
		.raddr(pick_q), .rdata(p_rdata)
	);
	ats_ram #(.WIDTH(TW), .DEPTH(MAX_BINS)) u_tmem (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);
	ats_ram #(.WIDTH(SEW), .DEPTH(MAX_BINS)) u_umem (
		.clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
		.raddr(u_raddr), .rdata(u_rdata)
	);
	ats_ram #(.WIDTH(SEW), .DEPTH(MAX_BINS)) u_omem (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	ats_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(div_quot)
	);
endmodule
`default_nettype wire

/* rtl/core/ats_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ats_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/ats_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ats_div
// Restoring divider: floor(num * 2^FRAC_W / den) for num <= den, one
// quotient bit per cycle; done pulses for one cycle once the quotient is complete.
// ----------------------------------------------------------------------------
module ats_div
	import ats_pkg::*;
#(
	parameter int DW = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [QW-1:0]      quot
);
	localparam int SW = $clog2(QW + 1);

	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quot_q;
	logic [SW-1:0] step_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;

	// first step has no shift since num <= den
	assign trial = (step_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == SW'(QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

/* rtl/core/ats_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ats_chk
// Port-level checks on the result channel of the sampler core.
// ----------------------------------------------------------------------------
module ats_chk
	import ats_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              valid,
	input wire logic              ready,
	input wire logic [IDX_W-1:0]  bin_index,
	input wire logic [PROB_W-1:0] probability,
	input wire logic [FRAC_W-1:0] remapped_fraction,
	input wire logic              status
);
	// no result right after a reset edge
	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !valid)
		else $error("result valid during reset");

	// stalled transaction stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(bin_index) && $stable(probability)
			&& $stable(remapped_fraction) && $stable(status))
		else $error("result payload changed while stalled");

	// error results carry zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status |-> bin_index == '0 && probability == '0
			&& remapped_fraction == '0)
		else $error("error result with nonzero fields");

	// probability never exceeds one
	a_prob_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !status |-> probability <= PROB_W'(ONE_FX))
		else $error("probability above one");
endmodule

bind alias_table_sampler_core ats_chk u_ats_chk (
	.clk(clk),
	.arst_n(arst_n),
	.valid(rsp.valid),
	.ready(rsp.ready),
	.bin_index(rsp.bin_index),
	.probability(rsp.probability),
	.remapped_fraction(rsp.remapped_fraction),
	.status(rsp.status)
);
`default_nettype wire
